### rtl/ctss_pkg.sv
`timescale 1ns / 1ps

package ctss_pkg;

    localparam int COLUMN_BITS_DEF = 16;
    localparam int LINE_BITS_DEF   = 32;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_AW        = 2;

    localparam logic [30:0] INT_TOP = 31'h7FFF_FFFF;

    localparam logic [5:0] KIND_END    = 6'd0;
    localparam logic [5:0] KIND_LBRACE = 6'd1;
    localparam logic [5:0] KIND_RBRACE = 6'd2;
    localparam logic [5:0] KIND_LPAREN = 6'd3;
    localparam logic [5:0] KIND_RPAREN = 6'd4;
    localparam logic [5:0] KIND_SEMI   = 6'd5;
    localparam logic [5:0] KIND_COLON  = 6'd6;
    localparam logic [5:0] KIND_QUEST  = 6'd7;
    localparam logic [5:0] KIND_COMMA  = 6'd8;
    localparam logic [5:0] KIND_KW0    = 6'd9;
    localparam logic [5:0] KIND_IDENT  = 6'd20;
    localparam logic [5:0] KIND_INT    = 6'd21;
    localparam logic [5:0] KIND_MINUS  = 6'd22;
    localparam logic [5:0] KIND_TILDE  = 6'd23;
    localparam logic [5:0] KIND_PLUS   = 6'd24;
    localparam logic [5:0] KIND_STAR   = 6'd25;
    localparam logic [5:0] KIND_SLASH  = 6'd26;
    localparam logic [5:0] KIND_PCT    = 6'd27;
    localparam logic [5:0] KIND_AMP    = 6'd28;
    localparam logic [5:0] KIND_BAR    = 6'd29;
    localparam logic [5:0] KIND_CARET  = 6'd30;
    localparam logic [5:0] KIND_SHL    = 6'd31;
    localparam logic [5:0] KIND_SHR    = 6'd32;
    localparam logic [5:0] KIND_ASSIGN = 6'd33;
    localparam logic [5:0] KIND_NOT    = 6'd34;
    localparam logic [5:0] KIND_LAND   = 6'd35;
    localparam logic [5:0] KIND_LOR    = 6'd36;
    localparam logic [5:0] KIND_EQ     = 6'd37;
    localparam logic [5:0] KIND_NE     = 6'd38;
    localparam logic [5:0] KIND_LT     = 6'd39;
    localparam logic [5:0] KIND_LE     = 6'd40;
    localparam logic [5:0] KIND_GT     = 6'd41;
    localparam logic [5:0] KIND_GE     = 6'd42;
    localparam logic [5:0] KIND_ADDEQ  = 6'd43;
    localparam logic [5:0] KIND_SUBEQ  = 6'd44;
    localparam logic [5:0] KIND_DIVEQ  = 6'd45;
    localparam logic [5:0] KIND_MULEQ  = 6'd46;
    localparam logic [5:0] KIND_MODEQ  = 6'd47;
    localparam logic [5:0] KIND_ANDEQ  = 6'd48;
    localparam logic [5:0] KIND_OREQ   = 6'd49;
    localparam logic [5:0] KIND_XOREQ  = 6'd50;
    localparam logic [5:0] KIND_SHLEQ  = 6'd51;
    localparam logic [5:0] KIND_SHREQ  = 6'd52;
    localparam logic [5:0] KIND_INC    = 6'd53;
    localparam logic [5:0] KIND_DEC    = 6'd54;
    localparam logic [5:0] KIND_ERROR  = 6'd55;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN = 2'd1;
    localparam logic [1:0] ERR_BADNUM  = 2'd2;
    localparam logic [1:0] ERR_RUNAWAY = 2'd3;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_END  = 1'b1;

    localparam int KW_COUNT = 11;

    localparam logic [63:0] KW_STR [KW_COUNT] = '{
        64'("int"), 64'("void"), 64'("return"), 64'("if"), 64'("else"),
        64'("for"), 64'("while"), 64'("do"), 64'("break"),
        64'("continue"), 64'("goto")
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd4, 4'd6, 4'd2, 4'd4, 4'd3, 4'd5, 4'd2, 4'd5, 4'd8, 4'd4
    };

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_OPER,
        MODE_SHIFT,
        MODE_SLASH,
        MODE_LCMT,
        MODE_BCMT,
        MODE_BSTAR,
        MODE_WORD,
        MODE_NUM
    } mode_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [30:0] value;
        logic [31:0] line;
        logic [15:0] column;
        logic [15:0] length;
        logic [1:0]  err;
        logic        last;
    } tok_t;

    function automatic logic [7:0] kw_char(input logic [3:0] idx, input logic [2:0] pos);
        logic [5:0] base;
        base = {3'(KW_LEN[idx] - 4'd1 - {1'b0, pos}), 3'b000};
        return 8'(KW_STR[idx] >> base);
    endfunction

    function automatic tok_t mk_tok(input logic [5:0] kind, input logic [30:0] value,
                                    input logic [31:0] line, input logic [15:0] column,
                                    input logic [16:0] len, input logic [1:0] err);
        tok_t t;
        t.kind   = kind;
        t.value  = value;
        t.line   = line;
        t.column = column;
        t.length = len[16] ? 16'hFFFF : len[15:0];
        t.err    = err;
        t.last   = 1'b0;
        return t;
    endfunction

    function automatic logic [5:0] single_op_kind(input logic [7:0] p);
        logic [5:0] k;
        case (p)
            "-":     k = KIND_MINUS;
            "+":     k = KIND_PLUS;
            "*":     k = KIND_STAR;
            "%":     k = KIND_PCT;
            "&":     k = KIND_AMP;
            "|":     k = KIND_BAR;
            "^":     k = KIND_CARET;
            "=":     k = KIND_ASSIGN;
            "!":     k = KIND_NOT;
            "<":     k = KIND_LT;
            default: k = KIND_GT;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
        logic [5:0] k;
        k = KIND_END;
        if (c == "=") begin
            case (p)
                "+":     k = KIND_ADDEQ;
                "-":     k = KIND_SUBEQ;
                "*":     k = KIND_MULEQ;
                "%":     k = KIND_MODEQ;
                "&":     k = KIND_ANDEQ;
                "|":     k = KIND_OREQ;
                "^":     k = KIND_XOREQ;
                "=":     k = KIND_EQ;
                "!":     k = KIND_NE;
                "<":     k = KIND_LE;
                ">":     k = KIND_GE;
                default: k = KIND_END;
            endcase
        end
        else if (c == p) begin
            case (p)
                "+":     k = KIND_INC;
                "-":     k = KIND_DEC;
                "&":     k = KIND_LAND;
                "|":     k = KIND_LOR;
                default: k = KIND_END;
            endcase
        end
        return k;
    endfunction

endpackage

### rtl/ctss_scan.sv
`timescale 1ns / 1ps

module ctss_scan #(
    parameter int COLUMN_BITS = ctss_pkg::COLUMN_BITS_DEF,
    parameter int LINE_BITS   = ctss_pkg::LINE_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  logic           req_type,
    input  logic [7:0]     ch,
    output logic           push0,
    output logic           push1,
    output ctss_pkg::tok_t tok0,
    output ctss_pkg::tok_t tok1
);
    import ctss_pkg::*;

    mode_t                  mode_reg, mode_next;
    logic [7:0]             pend_reg, pend_next;
    logic [KW_COUNT-1:0]    cand_reg, cand_next;
    logic [15:0]            wlen_reg, wlen_next;
    logic [30:0]            acc_reg, acc_next;
    logic [LINE_BITS-1:0]   line_reg, line_next, sline_reg, sline_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next, scol_reg, scol_next;
    logic                   halt_reg, halt_next;

    logic [COLUMN_BITS-1:0] col_inc;
    logic [LINE_BITS-1:0]   line_inc;
    logic                   is_alpha, is_digit;
    logic [34:0]            acc_mul;
    logic [5:0]             word_kind, pk;
    tok_t                   pend_tok;
    logic                   pend_v;

    mode_t                  f_mode;
    logic [7:0]             f_pend;
    logic [KW_COUNT-1:0]    f_cand;
    logic [15:0]            f_wlen;
    logic [30:0]            f_acc;
    logic [LINE_BITS-1:0]   f_line;
    logic [COLUMN_BITS-1:0] f_col;
    logic                   f_halt, f_emit;
    tok_t                   f_tok;

    logic                   use_fresh, p_v;
    tok_t                   p_tok;

    assign col_inc  = (&col_reg) ? col_reg : col_reg + 1'b1;
    assign line_inc = (&line_reg) ? line_reg : line_reg + 1'b1;
    assign is_alpha = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_";
    assign is_digit = ch >= "0" && ch <= "9";
    assign acc_mul  = 35'({acc_reg, 3'b000}) + 35'({acc_reg, 1'b0}) + 35'(ch[3:0]);

    always_comb
    begin
        word_kind = KIND_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (cand_reg[i] && wlen_reg == 16'(KW_LEN[i]))
                word_kind = KIND_KW0 + 6'(i);
        end
    end

    // The token held back by the current mode, if the next byte does not extend it.
    always_comb
    begin
        pend_v   = 1'b1;
        pend_tok = mk_tok(KIND_END, '0, 32'(sline_reg), 16'(scol_reg), 17'd0, ERR_NONE);
        unique case (mode_reg)
            MODE_OPER:
                pend_tok = mk_tok(single_op_kind(pend_reg), '0, 32'(sline_reg),
                                  16'(scol_reg), 17'd1, ERR_NONE);
            MODE_SHIFT:
                pend_tok = mk_tok((pend_reg == "<") ? KIND_SHL : KIND_SHR, '0,
                                  32'(sline_reg), 16'(scol_reg), 17'd2, ERR_NONE);
            MODE_SLASH:
                pend_tok = mk_tok(KIND_SLASH, '0, 32'(sline_reg), 16'(scol_reg),
                                  17'd1, ERR_NONE);
            MODE_WORD:
                pend_tok = mk_tok(word_kind, '0, 32'(sline_reg), 16'(scol_reg),
                                  17'(wlen_reg), ERR_NONE);
            MODE_NUM:
                pend_tok = mk_tok(KIND_INT, acc_reg, 32'(sline_reg), 16'(scol_reg),
                                  17'(wlen_reg), ERR_NONE);
            MODE_BCMT, MODE_BSTAR:
                pend_tok = mk_tok(KIND_ERROR, '0, 32'(sline_reg), 16'(scol_reg),
                                  17'd2, ERR_RUNAWAY);
            default:
                pend_v = 1'b0;
        endcase
    end

    // Effect of a byte in the idle mode: skip it, open a token or flag an error.
    always_comb
    begin
        f_mode = MODE_IDLE;
        f_pend = pend_reg;
        f_cand = cand_reg;
        f_wlen = wlen_reg;
        f_acc  = acc_reg;
        f_line = line_reg;
        f_col  = col_inc;
        f_halt = 1'b0;
        f_emit = 1'b0;
        f_tok  = mk_tok(KIND_END, '0, 32'(line_reg), 16'(col_reg), 17'd1, ERR_NONE);
        unique case (ch) inside
            " ", "\t": ;
            "\n":
            begin
                f_line = line_inc;
                f_col  = '0;
            end
            "{", "}", "(", ")", ";", ":", "?", ",", "~":
            begin
                f_emit = 1'b1;
                case (ch)
                    "{":     f_tok.kind = KIND_LBRACE;
                    "}":     f_tok.kind = KIND_RBRACE;
                    "(":     f_tok.kind = KIND_LPAREN;
                    ")":     f_tok.kind = KIND_RPAREN;
                    ";":     f_tok.kind = KIND_SEMI;
                    ":":     f_tok.kind = KIND_COLON;
                    "?":     f_tok.kind = KIND_QUEST;
                    ",":     f_tok.kind = KIND_COMMA;
                    default: f_tok.kind = KIND_TILDE;
                endcase
            end
            "/":
                f_mode = MODE_SLASH;
            "+", "-", "*", "%", "&", "|", "^", "=", "!", "<", ">":
            begin
                f_mode = MODE_OPER;
                f_pend = ch;
            end
            default:
            begin
                if (is_alpha) begin
                    f_mode = MODE_WORD;
                    f_wlen = 16'd1;
                    for (int i = 0; i < KW_COUNT; i++)
                        f_cand[i] = kw_char(4'(i), 3'd0) == ch;
                end
                else if (is_digit) begin
                    f_mode = MODE_NUM;
                    f_wlen = 16'd1;
                    f_acc  = 31'(ch[3:0]);
                end
                else begin
                    f_emit = 1'b1;
                    f_halt = 1'b1;
                    f_tok  = mk_tok(KIND_ERROR, '0, 32'(line_reg), 16'(col_reg), 17'd1,
                                    ERR_UNKNOWN);
                end
            end
        endcase
    end

    always_comb
    begin
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        cand_next  = cand_reg;
        wlen_next  = wlen_reg;
        acc_next   = acc_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        sline_next = sline_reg;
        scol_next  = scol_reg;
        halt_next  = halt_reg;
        use_fresh  = 1'b0;
        p_v        = 1'b0;
        p_tok      = pend_tok;
        pk         = pair_kind(pend_reg, ch);
        push0      = 1'b0;
        push1      = 1'b0;
        tok0       = pend_tok;
        tok1       = f_tok;

        if (take && req_type == REQ_END) begin
            if (!halt_reg) begin
                tok1 = mk_tok(KIND_END, '0, 32'(line_reg), 16'(col_reg), 17'd0, ERR_NONE);
                if (pend_v) begin
                    push0 = 1'b1;
                    push1 = !(mode_reg == MODE_BCMT || mode_reg == MODE_BSTAR);
                    tok0.last = !push1;
                    tok1.last = 1'b1;
                end
                else begin
                    push0     = 1'b1;
                    tok0      = tok1;
                    tok0.last = 1'b1;
                end
            end
            mode_next  = MODE_IDLE;
            pend_next  = '0;
            cand_next  = '1;
            wlen_next  = '0;
            acc_next   = '0;
            line_next  = LINE_BITS'(1);
            col_next   = '0;
            sline_next = LINE_BITS'(1);
            scol_next  = '0;
            halt_next  = 1'b0;
        end
        else if (take && !halt_reg) begin
            col_next = col_inc;
            unique case (mode_reg)
                MODE_OPER:
                    if ((pend_reg == "<" || pend_reg == ">") && ch == pend_reg)
                        mode_next = MODE_SHIFT;
                    else if (pk != KIND_END) begin
                        p_v       = 1'b1;
                        p_tok     = mk_tok(pk, '0, 32'(sline_reg), 16'(scol_reg), 17'd2,
                                           ERR_NONE);
                        mode_next = MODE_IDLE;
                    end
                    else begin
                        p_v       = 1'b1;
                        use_fresh = 1'b1;
                    end
                MODE_SHIFT:
                    if (ch == "=") begin
                        p_v       = 1'b1;
                        p_tok     = mk_tok((pend_reg == "<") ? KIND_SHLEQ : KIND_SHREQ, '0,
                                           32'(sline_reg), 16'(scol_reg), 17'd3, ERR_NONE);
                        mode_next = MODE_IDLE;
                    end
                    else begin
                        p_v       = 1'b1;
                        use_fresh = 1'b1;
                    end
                MODE_SLASH:
                    if (ch == "/")
                        mode_next = MODE_LCMT;
                    else if (ch == "*")
                        mode_next = MODE_BCMT;
                    else if (ch == "=") begin
                        p_v       = 1'b1;
                        p_tok     = mk_tok(KIND_DIVEQ, '0, 32'(sline_reg), 16'(scol_reg),
                                           17'd2, ERR_NONE);
                        mode_next = MODE_IDLE;
                    end
                    else begin
                        p_v       = 1'b1;
                        use_fresh = 1'b1;
                    end
                MODE_LCMT:
                    use_fresh = ch == "\n";
                MODE_BCMT, MODE_BSTAR:
                    if (ch == "\n") begin
                        line_next = line_inc;
                        col_next  = '0;
                        mode_next = MODE_BCMT;
                    end
                    else if (ch == "/" && mode_reg == MODE_BSTAR)
                        mode_next = MODE_IDLE;
                    else
                        mode_next = (ch == "*") ? MODE_BSTAR : MODE_BCMT;
                MODE_WORD:
                    if (is_alpha || is_digit) begin
                        for (int i = 0; i < KW_COUNT; i++) begin
                            if (wlen_reg >= 16'(KW_LEN[i]) ||
                                kw_char(4'(i), wlen_reg[2:0]) != ch)
                                cand_next[i] = 1'b0;
                        end
                        wlen_next = (&wlen_reg) ? wlen_reg : wlen_reg + 16'd1;
                    end
                    else begin
                        p_v       = 1'b1;
                        use_fresh = 1'b1;
                    end
                MODE_NUM:
                    if (is_digit) begin
                        acc_next  = (acc_mul > 35'(INT_TOP)) ? INT_TOP : acc_mul[30:0];
                        wlen_next = (&wlen_reg) ? wlen_reg : wlen_reg + 16'd1;
                    end
                    else if (is_alpha) begin
                        p_v       = 1'b1;
                        p_tok     = mk_tok(KIND_ERROR, '0, 32'(sline_reg), 16'(scol_reg),
                                           17'(wlen_reg) + 17'd1, ERR_BADNUM);
                        halt_next = 1'b1;
                    end
                    else begin
                        p_v       = 1'b1;
                        use_fresh = 1'b1;
                    end
                default:
                    use_fresh = 1'b1;
            endcase

            if (use_fresh) begin
                mode_next  = f_mode;
                pend_next  = f_pend;
                cand_next  = f_cand;
                wlen_next  = f_wlen;
                acc_next   = f_acc;
                line_next  = f_line;
                col_next   = f_col;
                sline_next = line_reg;
                scol_next  = col_reg;
                halt_next  = f_halt;
            end

            if (p_v) begin
                push0     = 1'b1;
                tok0      = p_tok;
                push1     = use_fresh && f_emit;
                tok0.last = !push1;
                tok1.last = 1'b1;
            end
            else begin
                push0     = use_fresh && f_emit;
                tok0      = f_tok;
                tok0.last = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_IDLE;
            pend_reg  <= '0;
            cand_reg  <= '1;
            wlen_reg  <= '0;
            acc_reg   <= '0;
            line_reg  <= LINE_BITS'(1);
            col_reg   <= '0;
            sline_reg <= LINE_BITS'(1);
            scol_reg  <= '0;
            halt_reg  <= 1'b0;
        end
        else begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            cand_reg  <= cand_next;
            wlen_reg  <= wlen_next;
            acc_reg   <= acc_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            sline_reg <= sline_next;
            scol_reg  <= scol_next;
            halt_reg  <= halt_next;
        end
    end

endmodule

### rtl/ctss_queue.sv
`timescale 1ns / 1ps

module ctss_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push0,
    input  logic           push1,
    input  ctss_pkg::tok_t tok0,
    input  ctss_pkg::tok_t tok1,
    input  logic           pop,
    output logic           room2,
    output logic           nonempty,
    output ctss_pkg::tok_t head
);
    import ctss_pkg::*;

    tok_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [QUEUE_AW:0]   cnt_reg, cnt_next;

    assign room2    = cnt_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2);
    assign nonempty = cnt_reg != '0;
    assign head     = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg + QUEUE_AW'(push0) + QUEUE_AW'(push1);
        rp_next  = rp_reg + QUEUE_AW'(pop);
        cnt_next = cnt_reg + (QUEUE_AW + 1)'(push0) + (QUEUE_AW + 1)'(push1)
                   - (QUEUE_AW + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push0)
            mem_reg[wp_reg] <= tok0;
        if (push1)
            mem_reg[wp_reg + QUEUE_AW'(1)] <= tok1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### rtl/ctss_emit.sv
`timescale 1ns / 1ps

module ctss_emit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           nonempty,
    input  ctss_pkg::tok_t head,
    output logic           pop,
    input  logic           out_stall,
    output logic           out_valid,
    output ctss_pkg::tok_t tok
);
    import ctss_pkg::*;

    logic valid_reg;
    tok_t tok_reg;

    assign pop       = nonempty && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;
    assign tok       = tok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || !out_stall)
            valid_reg <= nonempty;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            tok_reg <= head;
    end

endmodule

### rtl/c_subset_token_scanner.sv
`timescale 1ns / 1ps

// Streaming scanner for a small C subset. It takes one word per cycle, either a source
// byte or an end-of-text marker, and produces zero, one or two token words for each; the
// last flag marks the final token caused by an input word. A byte is accepted in the
// cycle it arrives, and tokens leave through a four-word queue and an output register, so
// input is only held off while the queue has fewer than two free places. A token that
// needs lookahead is pushed when the following byte or the end-of-text marker is taken.
module c_subset_token_scanner #(
    parameter int COLUMN_BITS = ctss_pkg::COLUMN_BITS_DEF,
    parameter int LINE_BITS   = ctss_pkg::LINE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  token_kind,
    output logic [30:0] int_value,
    output logic [31:0] line_number,
    output logic [15:0] column_number,
    output logic [15:0] token_length,
    output logic [1:0]  error_code,
    output logic        last
);
    import ctss_pkg::*;

    logic take, push0, push1, pop, room2, nonempty;
    tok_t tok0, tok1, head, tok;

    assign in_stall = !room2;
    assign take     = in_valid && room2;

    ctss_scan #(
        .COLUMN_BITS(COLUMN_BITS),
        .LINE_BITS  (LINE_BITS)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .req_type(req_type),
        .ch      (ch),
        .push0   (push0),
        .push1   (push1),
        .tok0    (tok0),
        .tok1    (tok1)
    );

    ctss_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push0   (push0),
        .push1   (push1),
        .tok0    (tok0),
        .tok1    (tok1),
        .pop     (pop),
        .room2   (room2),
        .nonempty(nonempty),
        .head    (head)
    );

    ctss_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .nonempty (nonempty),
        .head     (head),
        .pop      (pop),
        .out_stall(out_stall),
        .out_valid(out_valid),
        .tok      (tok)
    );

    assign token_kind    = tok.kind;
    assign int_value     = tok.value;
    assign line_number   = tok.line;
    assign column_number = tok.column;
    assign token_length  = tok.length;
    assign error_code    = tok.err;
    assign last          = tok.last;

endmodule

### rtl/ctss_checker.sv
`timescale 1ns / 1ps

module ctss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        req_type,
    input logic [7:0]  ch,
    input logic        out_valid,
    input logic        out_stall,
    input logic [5:0]  token_kind,
    input logic [30:0] int_value,
    input logic [31:0] line_number,
    input logic [15:0] token_length,
    input logic [1:0]  error_code,
    input logic        last
);
    import ctss_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(token_kind) && $stable(last))
        else $error("stalled token changed");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(req_type) && $stable(ch))
        else $error("stalled input word changed");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((token_kind == KIND_ERROR) == (error_code != ERR_NONE)))
        else $error("error code does not match token kind");

    a_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind != KIND_INT |-> int_value == '0 && line_number != '0)
        else $error("value on a non-integer token or line zero");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == KIND_END |-> last && token_length == '0)
        else $error("end token is not final");

endmodule

bind c_subset_token_scanner ctss_checker u_ctss_checker (.*);
